[design/mwlfo_pkg.sv]
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared constants, waveshape codes, register indexes and the quarter-wave
// sine entry generator for the multi-waveform LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mwlfo_pkg;

  // Default sizes
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned DEPTH_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH           = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVESHAPE       = 2'd2;

  localparam logic [CFG_DATA_W-1:0] PHASE_INCREMENT_RST = 32'd97391;
  localparam logic [DEPTH_W-1:0]    DEPTH_RST           = 16'd32768;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_SAW      = 2'd2,
    SHAPE_TRIANGLE = 2'd3
  } shape_t;

  // pi/2 in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // One quarter-wave entry, Taylor series to x^15 in Q30, then scaled to
  // full scale 2^(sbits-1) with rounding. Used at elaboration only.
  function automatic longint unsigned sine_entry(input int unsigned idx,
                                                 input int unsigned tbits,
                                                 input int unsigned sbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          fs;
    longint          v;
    x    = (HALF_PI_Q30 * longint'(idx)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    fs = longint'(1) << (sbits - 1);
    v  = longint'((longint'(sum) * fs + (longint'(1) << 29)) >>> 30);
    if (v > fs) begin
      v = fs;
    end
    return longint'(v);
  endfunction

endpackage

`default_nettype wire

[design/multi_waveform_lfo_unit.sv]
// ----------------------------------------------------------------------------
// multi_waveform_lfo_unit
// Phase-accumulator LFO: sine (quarter-wave ROM), square, saw and triangle,
// scaled by a Q1.15 depth and saturated.
// ----------------------------------------------------------------------------
// Pipeline: ROM read stage (stage 1 register), then depth multiply/round/saturate
//   into the output register, which drives out_valid.
// Throughput: 1 request per cycle while out_ready does not stall the pipeline.
// Reset: synchronous, active low; phase 0, increment 97391, depth 1.0,
//   shape sine, pipeline empty. The sine ROM is constant, no init pass.
`default_nettype none

module multi_waveform_lfo_unit #(
  parameter int unsigned PHASE_BITS      = mwlfo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = mwlfo_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = mwlfo_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // config
  input  wire                                     cfg_we,
  input  wire  [mwlfo_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [mwlfo_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // request
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire                                     in_restart,
  // result
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [SAMPLE_BITS-1:0]           out_sample
);

  localparam int unsigned QTR_LEN = 1 << SINE_TABLE_BITS;
  localparam int unsigned ADDR_W  = SINE_TABLE_BITS + 1;
  localparam int unsigned WAVE_W  = SAMPLE_BITS + 1;      // -FS..FS
  localparam int unsigned EXT_W   = SAMPLE_BITS + 3;
  localparam int unsigned PROD_W  = WAVE_W + mwlfo_pkg::DEPTH_W + 1;

  localparam logic signed [EXT_W-1:0]  FS_X   = EXT_W'(1) <<< (SAMPLE_BITS - 1);
  localparam logic signed [WAVE_W-1:0] FS_W   = WAVE_W'(FS_X);
  localparam logic signed [PROD_W-1:0] RND    = PROD_W'(1) <<< 14;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(FS_X) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(FS_X);
  localparam logic [ADDR_W-1:0]        QTR_A  = ADDR_W'(QTR_LEN);

  // --------------------------------------------------------------------------
  // Quarter-wave sine ROM
  // --------------------------------------------------------------------------
  typedef logic [WAVE_W-1:0] rom_t [QTR_LEN+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i <= QTR_LEN; i++) begin
      r[i] = WAVE_W'(mwlfo_pkg::sine_entry(i, SINE_TABLE_BITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [mwlfo_pkg::CFG_DATA_W-1:0] incr_r;
  logic [mwlfo_pkg::DEPTH_W-1:0]    depth_r;
  mwlfo_pkg::shape_t                shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incr_r  <= mwlfo_pkg::PHASE_INCREMENT_RST;
      depth_r <= mwlfo_pkg::DEPTH_RST;
      shape_r <= mwlfo_pkg::SHAPE_SINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwlfo_pkg::REG_PHASE_INCREMENT: incr_r  <= cfg_wdata;
        mwlfo_pkg::REG_DEPTH:           depth_r <= cfg_wdata[mwlfo_pkg::DEPTH_W-1:0];
        mwlfo_pkg::REG_WAVESHAPE:       shape_r <= mwlfo_pkg::shape_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // increment or shape writes restart the phase
  logic cfg_clr;
  assign cfg_clr = cfg_we && (cfg_index == mwlfo_pkg::REG_PHASE_INCREMENT ||
                              cfg_index == mwlfo_pkg::REG_WAVESHAPE);

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic s1_vld_r;
  logic out_vld_r;
  logic adv;
  logic s1_en;
  logic in_acc;

  assign adv      = !out_vld_r || out_ready;
  assign s1_en    = !s1_vld_r || adv;
  assign in_ready = s1_en;
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Stage 0: phase, fraction, ROM address, non-sine shapes
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_use;
  logic [31:0]           frac;

  assign phase_use = in_restart ? '0 : phase_r;

  if (PHASE_BITS >= 32) begin : g_frac_hi
    assign frac = phase_use[PHASE_BITS-1 -: 32];
  end else begin : g_frac_lo
    assign frac = {phase_use, (32 - PHASE_BITS)'(0)};
  end

  logic [SINE_TABLE_BITS-1:0] s0_idx;
  logic [ADDR_W-1:0]          s0_addr;
  logic signed [EXT_W-1:0]    s0_wave_x;

  assign s0_idx  = frac[29 -: SINE_TABLE_BITS];
  assign s0_addr = frac[30] ? (QTR_A - {1'b0, s0_idx}) : {1'b0, s0_idx};

  always_comb begin
    unique case (shape_r)
      mwlfo_pkg::SHAPE_SQUARE:
        s0_wave_x = frac[31] ? FS_X : -FS_X;
      mwlfo_pkg::SHAPE_SAW:
        s0_wave_x = $signed({3'b000, frac[31 -: SAMPLE_BITS]}) - FS_X;
      mwlfo_pkg::SHAPE_TRIANGLE:
        s0_wave_x = frac[31] ? (EXT_W'(3) * FS_X) - $signed({2'b00, frac[31 -: WAVE_W]})
                             : $signed({3'b000, frac[30 -: SAMPLE_BITS]}) - FS_X;
      default:
        s0_wave_x = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cfg_clr) begin
      phase_r <= '0;
    end else if (in_acc) begin
      phase_r <= phase_use + PHASE_BITS'(incr_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: ROM data and wave registered
  // --------------------------------------------------------------------------
  logic [WAVE_W-1:0]        sine_q_r;
  logic signed [WAVE_W-1:0] wave_r;
  logic                     neg_r;
  mwlfo_pkg::shape_t        s1_shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sine_q_r   <= SINE_ROM[s0_addr];
      wave_r     <= WAVE_W'(s0_wave_x);
      neg_r      <= frac[31];
      s1_shape_r <= shape_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: depth scaling, round half up, saturate
  // --------------------------------------------------------------------------
  logic signed [WAVE_W-1:0] s1_w;
  logic signed [PROD_W-1:0] s1_prod;
  logic signed [PROD_W-1:0] s1_shr;
  logic signed [PROD_W-1:0] s1_sat;

  always_comb begin
    if (s1_shape_r == mwlfo_pkg::SHAPE_SINE) begin
      s1_w = neg_r ? -$signed(sine_q_r) : $signed(sine_q_r);
    end else begin
      s1_w = wave_r;
    end
    s1_prod = PROD_W'(s1_w) * $signed({{(PROD_W-mwlfo_pkg::DEPTH_W){1'b0}}, depth_r});
    s1_shr  = (s1_prod + RND) >>> 15;
    priority if (s1_shr > SAT_HI) begin
      s1_sat = SAT_HI;
    end else if (s1_shr < SAT_LO) begin
      s1_sat = SAT_LO;
    end else begin
      s1_sat = s1_shr;
    end
  end

  logic signed [SAMPLE_BITS-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      sample_r <= SAMPLE_BITS'(s1_sat);
    end
  end

  assign out_valid  = out_vld_r;
  assign out_sample = sample_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |=> s1_vld_r)
    else $error("stage 1 request dropped while stalled");

  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart && !cfg_we |=> phase_r == PHASE_BITS'(incr_r))
    else $error("restart did not advance from zero phase");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clr |=> phase_r == '0)
    else $error("increment/shape write did not clear phase");

  a_square_level: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_shape_r == mwlfo_pkg::SHAPE_SQUARE |-> wave_r == FS_W || wave_r == -FS_W)
    else $error("square wave not at full scale");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_waveform_lfo_unit. A scoreboard keeps its own
// copy of the oscillator (phase, increment, depth, shape, sine table) and
// predicts one sample per accepted request. Directed cases cover the table
// corners, all shapes and register masking. Random phases reprogram the
// block with random settings under varying backpressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PIPE_LATENCY = 2;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 48;
  localparam int QTR_LEN      = 1 << mwlfo_pkg::SINE_TABLE_BITS_DEF;
  localparam longint FS       = 64'sd32768;
  localparam logic [mwlfo_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  class lfo_scoreboard;
    int                            quarter_sine[0:QTR_LEN];
    logic [31:0]                   phase;
    logic [31:0]                   step;
    logic [mwlfo_pkg::DEPTH_W-1:0] gain;
    mwlfo_pkg::shape_t             shape;
    logic signed [15:0]            sample_q[$];
    int                            errors;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          v;
      for (int i = 0; i <= QTR_LEN; i++) begin
        x    = (mwlfo_pkg::HALF_PI_Q30 * longint'(i)) >> mwlfo_pkg::SINE_TABLE_BITS_DEF;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        // odd Taylor terms up to x^15, alternating sign
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        v = (sum * FS + (longint'(1) <<< 29)) >>> 30;
        if (v > FS) begin
          v = FS;
        end
        quarter_sine[i] = int'(v);
      end
      phase  = '0;
      step   = mwlfo_pkg::PHASE_INCREMENT_RST;
      gain   = mwlfo_pkg::DEPTH_RST;
      shape  = mwlfo_pkg::SHAPE_SINE;
      errors = 0;
    endfunction

    function void write_reg(logic [mwlfo_pkg::CFG_INDEX_W-1:0] idx,
                            logic [mwlfo_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mwlfo_pkg::REG_PHASE_INCREMENT: begin
          step  = data;
          phase = '0;
        end
        mwlfo_pkg::REG_DEPTH: begin
          gain = data[mwlfo_pkg::DEPTH_W-1:0];
        end
        mwlfo_pkg::REG_WAVESHAPE: begin
          shape = mwlfo_pkg::shape_t'(data[1:0]);
          phase = '0;
        end
        default: begin
        end
      endcase
    endfunction

    function longint shape_value(logic [31:0] f);
      longint m;
      case (shape)
        mwlfo_pkg::SHAPE_SINE: begin
          // odd quadrants read the table mirrored, upper half of the phase negated
          m = f[30] ? quarter_sine[QTR_LEN - int'(f[29:20])] : quarter_sine[f[29:20]];
          return f[31] ? -m : m;
        end
        mwlfo_pkg::SHAPE_SQUARE: begin
          return f[31] ? FS : -FS;
        end
        mwlfo_pkg::SHAPE_SAW: begin
          return longint'(f[31:16]) - FS;
        end
        default: begin
          return f[31] ? 3 * FS - longint'(f[31:15]) : longint'(f[30:15]) - FS;
        end
      endcase
    endfunction

    function void note_request(logic restart);
      longint w;
      longint r;
      if (restart) begin
        phase = '0;
      end
      w = shape_value(phase);
      r = (w * longint'(gain) + 64'sd16384) >>> 15;
      if (r > FS - 1) begin
        r = FS - 1;
      end
      if (r < -FS) begin
        r = -FS;
      end
      sample_q.push_back(16'(r));
      phase = phase + step;
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (sample_q.size() == 0) begin
        errors++;
        $display("%0t: sample %0d with no request outstanding", $time, got);
      end else begin
        want = sample_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: sample mismatch, expected %0d actual %0d", $time, want, got);
        end
      end
    endfunction

    function int outstanding();
      return sample_q.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we;
  logic [mwlfo_pkg::CFG_INDEX_W-1:0]  cfg_index;
  logic [mwlfo_pkg::CFG_DATA_W-1:0]   cfg_wdata;
  logic                               in_valid;
  logic                               in_ready;
  logic                               in_restart;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [15:0]                 out_sample;

  lfo_scoreboard sb;
  int            tx_idle;
  int            rx_idle;
  bit            hold_req;
  int            hold_cnt;

  multi_waveform_lfo_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

  always #5 clk = ~clk;

  // monitor: config writes, accepted requests and results, all at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.write_reg(cfg_index, cfg_wdata);
      end
      if (in_valid && in_ready) begin
        sb.note_request(in_restart);
      end
      if (out_valid && out_ready) begin
        sb.check_sample(out_sample);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on demand
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          @(posedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic program_reg(input logic [mwlfo_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mwlfo_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic send_request(input logic restart);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for every predicted sample, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    logic [mwlfo_pkg::CFG_DATA_W-1:0] inc;
    logic [mwlfo_pkg::CFG_DATA_W-1:0] gain;
    case ($urandom_range(5))
      0: inc = '0;
      1: inc = '1;
      2: inc = $urandom_range(65536, 1);
      3: inc = $urandom_range(1 << 24, 1 << 16);
      default: inc = $urandom();
    endcase
    case ($urandom_range(5))
      0: gain = '0;
      1: gain = 32'd32768;
      2: gain = 32'h0000_FFFF | ($urandom() << 16);
      3: gain = $urandom_range(32768);
      default: gain = $urandom();
    endcase
    if ($urandom_range(9) < 7) begin
      program_reg(mwlfo_pkg::REG_PHASE_INCREMENT, inc);
    end
    if ($urandom_range(9) < 7) begin
      program_reg(mwlfo_pkg::REG_DEPTH, gain);
    end
    if ($urandom_range(9) < 7) begin
      program_reg(mwlfo_pkg::REG_WAVESHAPE, $urandom());
    end
    if ($urandom_range(9) == 0) begin
      program_reg(REG_SPARE, $urandom());
    end
    cfg_we <= 1'b0;
    repeat (n) send_request($urandom_range(15) == 0);
    drain();
  endtask

  initial begin
    sb         = new();
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    out_ready  = 1'b0;
    tx_idle    = 32;
    rx_idle    = 73;
    hold_req   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, restart mid-stream
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain();

    // sine at quadrant boundaries: +1.0 must saturate
    program_reg(mwlfo_pkg::REG_PHASE_INCREMENT, 32'h4000_0000);
    program_reg(mwlfo_pkg::REG_WAVESHAPE, 32'(mwlfo_pkg::SHAPE_SINE));
    cfg_we <= 1'b0;
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    drain();

    program_reg(mwlfo_pkg::REG_PHASE_INCREMENT, 32'h8000_0000);
    program_reg(mwlfo_pkg::REG_WAVESHAPE, 32'(mwlfo_pkg::SHAPE_SQUARE));
    program_reg(mwlfo_pkg::REG_DEPTH, 32'd32768);
    cfg_we <= 1'b0;
    repeat (3) send_request(1'b0);
    drain();

    // oversized data gets masked; gain near 2.0 saturates
    program_reg(mwlfo_pkg::REG_DEPTH, 32'hFFFF_FFFF);
    program_reg(mwlfo_pkg::REG_PHASE_INCREMENT, 32'hFFFF_FFFF);
    program_reg(mwlfo_pkg::REG_WAVESHAPE, {30'h3FFF_FFFF, mwlfo_pkg::SHAPE_SAW});
    cfg_we <= 1'b0;
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain();

    program_reg(mwlfo_pkg::REG_PHASE_INCREMENT, 32'h2000_0000);
    program_reg(mwlfo_pkg::REG_WAVESHAPE, 32'(mwlfo_pkg::SHAPE_TRIANGLE));
    cfg_we <= 1'b0;
    repeat (5) send_request(1'b0);
    drain();

    // unused index must not disturb anything
    program_reg(REG_SPARE, $urandom());
    program_reg(mwlfo_pkg::REG_DEPTH, 32'd0);
    cfg_we <= 1'b0;
    send_request(1'b0);
    send_request(1'b1);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 4) begin
        tx_idle = 73;
        rx_idle = 32;
      end else if (p == 7) begin
        tx_idle  = 0;
        rx_idle  = 0;
        hold_req = 1'b1;
      end
      random_phase(PHASE_ITEMS);
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
